/* rtl/swtq_pkg.sv */
// Shared types, codes and field layout of the sorted wakeup timer queue.
package swtq_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 8;

  // Fixed field widths on the stream ports
  localparam int unsigned PortIdW = 8;
  localparam int unsigned WakeW   = 64;
  localparam int unsigned RelW    = 24;
  localparam int unsigned IdExtW  = 16;

  // Request data layout, lowest bit first
  localparam int unsigned InIdLsb      = 0;
  localparam int unsigned InWakeLsb    = InIdLsb + PortIdW;
  localparam int unsigned InPartialLsb = InWakeLsb + WakeW;
  localparam int unsigned InCounterLsb = InPartialLsb + 1;
  localparam int unsigned InUsedW      = InCounterLsb + RelW;
  localparam int unsigned InDataW      = ((InUsedW + 7) / 8) * 8;

  // Register map
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic        RegSelReload = 1'b0;

  // Request kinds
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqTick   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_WOKEN    = 2'd1,
    KIND_NONE     = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_TK_RD,
    ST_TK_CMP,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RESP
  } state_e;

  // One result on the outbound stream
  typedef struct packed {
    kind_e                kind;
    logic [PortIdW-1:0]   id;
    logic                 last;
  } result_t;

endpackage

/* rtl/swtq_mem.sv */
// Entry memory: one write port, one registered read port.
module swtq_mem #(
  parameter int unsigned DEPTH = swtq_pkg::QueueDepthDef,
  parameter int unsigned WIDTH = swtq_pkg::WakeW + swtq_pkg::IdBitsDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/swtq_ctrl.sv */
// Sequencer: kernel tick, queue pointers, insert walk, wake pops and result register.
module swtq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = swtq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = swtq_pkg::IdBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [swtq_pkg::RelW-1:0]            reload_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_type_i,
  input  logic [swtq_pkg::PortIdW-1:0]         in_id_i,
  input  logic [swtq_pkg::WakeW-1:0]           in_wake_i,
  input  logic                                 in_partial_i,
  input  logic [swtq_pkg::RelW-1:0]            in_counter_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output swtq_pkg::result_t                    out_o,
  output logic                                 mem_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_waddr_o,
  output logic [swtq_pkg::WakeW+ID_BITS-1:0]   mem_wdata_o,
  output logic                                 mem_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_raddr_o,
  input  logic [swtq_pkg::WakeW+ID_BITS-1:0]   mem_rdata_i
);
  import swtq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = WakeW + ID_BITS;

  state_e               state_q, state_d;
  logic [WakeW-1:0]     ktick_q, ktick_d;
  logic [RelW-1:0]      step_q, step_d;
  logic [WakeW-1:0]     wake_q, wake_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        idx_m1;
  logic                 pend_q, pend_d;
  logic [ID_BITS-1:0]   pend_id_q, pend_id_d;
  kind_e                resp_q, resp_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;

  logic                 slot_free;
  logic                 emit;
  result_t              emit_res;
  logic [RelW-1:0]      cnt_clamp;
  logic [WakeW-1:0]     rd_wake;
  logic [ID_BITS-1:0]   rd_id;
  logic [IdExtW-1:0]    in_id_ext;
  logic                 hit;

  // Physical slot of a queue position counted from the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Stored identifier to port width
  function automatic logic [PortIdW-1:0] id_out(input logic [ID_BITS-1:0] id);
    logic [IdExtW-1:0] ext;
    ext = IdExtW'(id);
    return ext[PortIdW-1:0];
  endfunction

  assign rd_wake   = mem_rdata_i[WakeW-1:0];
  assign rd_id     = mem_rdata_i[EW-1:WakeW];
  assign in_id_ext = IdExtW'(in_id_i);
  assign idx_m1    = idx_q - 1'b1;
  assign hit       = rd_wake < ktick_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_clamp = (in_counter_i > reload_i) ? reload_i : in_counter_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Next state, memory accesses and result emission
  always_comb begin
    state_d     = state_q;
    ktick_d     = ktick_q;
    step_d      = step_q;
    wake_d      = wake_q;
    id_d        = id_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    resp_d      = resp_q;
    emit        = 1'b0;
    emit_res    = '{kind: KIND_NONE, id: '0, last: 1'b1};
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = {id_q, wake_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          wake_d = in_wake_i;
          id_d   = in_id_ext[ID_BITS-1:0];
          step_d = in_partial_i ? (reload_i - cnt_clamp) : reload_i;
          idx_d  = count_q;
          pend_d = 1'b0;
          if (in_type_i == ReqTick) begin
            state_d = ST_STEP;
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            resp_d  = KIND_FULL;
            state_d = ST_RESP;
          end else begin
            state_d = ST_INS_RD;
          end
        end
      end

      ST_STEP: begin
        ktick_d = ktick_q + WakeW'(step_q);
        state_d = ST_TK_RD;
      end

      // Fetch the head entry, or close the tick on an empty queue
      ST_TK_RD: begin
        if (count_q == '0) begin
          if (pend_q) begin
            if (slot_free) begin
              emit     = 1'b1;
              emit_res = '{kind: KIND_WOKEN, id: id_out(pend_id_q), last: 1'b1};
              state_d  = ST_IDLE;
            end
          end else begin
            resp_d  = KIND_NONE;
            state_d = ST_RESP;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = head_q;
          state_d     = ST_TK_CMP;
        end
      end

      // A pending wakeup goes out once it is known whether another follows
      ST_TK_CMP: begin
        if (!pend_q) begin
          if (hit) begin
            pend_d    = 1'b1;
            pend_id_d = rd_id;
            head_d    = phys(head_q, AW'(1));
            count_d   = count_q - 1'b1;
            state_d   = ST_TK_RD;
          end else begin
            resp_d  = KIND_NONE;
            state_d = ST_RESP;
          end
        end else if (slot_free) begin
          emit     = 1'b1;
          emit_res = '{kind: KIND_WOKEN, id: id_out(pend_id_q), last: !hit};
          if (hit) begin
            pend_id_d = rd_id;
            head_d    = phys(head_q, AW'(1));
            count_d   = count_q - 1'b1;
            state_d   = ST_TK_RD;
          end else begin
            pend_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      // Walk from the tail toward the head
      ST_INS_RD: begin
        if (idx_q == '0) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = head_q;
          count_d     = count_q + 1'b1;
          resp_d      = KIND_ACCEPTED;
          state_d     = ST_RESP;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = phys(head_q, idx_m1[AW-1:0]);
          state_d     = ST_INS_CMP;
        end
      end

      // Shift a later entry up one slot, or drop the new one in place
      ST_INS_CMP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = phys(head_q, idx_q[AW-1:0]);
        if (rd_wake > wake_q) begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_m1;
          state_d     = ST_INS_RD;
        end else begin
          count_d = count_q + 1'b1;
          resp_d  = KIND_ACCEPTED;
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          emit     = 1'b1;
          emit_res = '{kind: resp_q, id: '0, last: 1'b1};
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = emit_res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ktick_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ktick_q     <= ktick_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    wake_q    <= wake_d;
    id_q      <= id_d;
    idx_q     <= idx_d;
    pend_id_q <= pend_id_d;
    resp_q    <= resp_d;
    out_q     <= out_d;
  end

endmodule

/* rtl/sorted_wakeup_timer_queue.sv */
// Top level of the sorted wakeup timer queue: register port, sequencer and entry memory.
//
// Requests arrive on the s_axis channel; tuser selects insert (0) or timer tick (1).
// Results leave on the m_axis channel: tuser carries the kind, tdata the woken
// thread and tlast marks the final result of each request.
// An insert answers with one accepted or queue-full result. It walks from the
// tail and moves each later entry up one slot, reading it and then writing it
// one slot further on, until the new entry drops into place.
// A tick adds the period step to the 64-bit kernel tick, then reads and compares
// head entries on the single memory read port, waking each one that is now due,
// until one is not yet due or the queue is empty.
// One request is worked at a time; the next is taken when the sequencer is idle,
// even while the last result still sits in the output register.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before issuing the next one; nothing is dropped.
// Reset empties the queue, clears the kernel tick and sets reload_value to
// 0xFFFFFF; memory contents are not cleared, since only queued entries are read.
// reload_value lies at byte address 0 of the register port.
module sorted_wakeup_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = swtq_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = swtq_pkg::IdBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swtq_pkg::ApbAddrW-1:0]   paddr,
  input  logic [swtq_pkg::ApbDataW-1:0]   pwdata,
  output logic [swtq_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  // Requests
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // thread_id[7:0], wake_tick[71:8], partial_tick[72], counter_value[96:73]
  input  logic [swtq_pkg::InDataW-1:0]    s_axis_tdata_i,
  // req_type[0]
  input  logic                            s_axis_tuser_i,
  // Results
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // woken_id[7:0]
  output logic [swtq_pkg::PortIdW-1:0]    m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]                      m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import swtq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned EW = WakeW + ID_BITS;

  logic [RelW-1:0] reload_q;
  logic            cfg_wr;
  result_t         res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [EW-1:0]   mem_rdata;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegSelReload) ? ApbDataW'(reload_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '1;
    end else if (cfg_wr && paddr[2] == RegSelReload) begin
      reload_q <= pwdata[RelW-1:0];
    end
  end

  // Sequencer
  swtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reload_i     (reload_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_type_i    (s_axis_tuser_i),
    .in_id_i      (s_axis_tdata_i[InIdLsb +: PortIdW]),
    .in_wake_i    (s_axis_tdata_i[InWakeLsb +: WakeW]),
    .in_partial_i (s_axis_tdata_i[InPartialLsb]),
    .in_counter_i (s_axis_tdata_i[InCounterLsb +: RelW]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Entry memory: wake tick in the low bits, thread above
  swtq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata_o = res.id;
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

/* test/swtq_checker.sv */
// Checker for the sorted wakeup timer queue: predicts results and compares them with the output stream.
module swtq_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Register port, observed only
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [swtq_pkg::ApbAddrW-1:0]  paddr,
  input  logic [swtq_pkg::ApbDataW-1:0]  pwdata,
  // Request stream, observed only
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // thread_id[7:0], wake_tick[71:8], partial_tick[72], counter_value[96:73]
  input  logic [swtq_pkg::InDataW-1:0]   s_tdata_i,
  // req_type[0]
  input  logic                           s_tuser_i,
  // Result stream, observed only
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // woken_id[7:0]
  input  logic [swtq_pkg::PortIdW-1:0]   m_tdata_i,
  // kind[1:0]
  input  logic [1:0]                     m_tuser_i,
  input  logic                           m_tlast_i,
  // Status toward the testbench top
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    request_count_o,
  output int unsigned                    result_count_o,
  output int unsigned                    woken_count_o,
  output int unsigned                    full_count_o
);
  import swtq_pkg::*;

  localparam int unsigned ReportMax = 10;

  // Shadow copy of the kernel tick, the sleep queue and the reload register
  logic [WakeW-1:0]   kernel_now;
  logic [WakeW-1:0]   sleep_wake [QueueDepthDef];
  logic [PortIdW-1:0] sleep_id   [QueueDepthDef];
  int                 sleep_count;
  logic [RelW-1:0]    reload_now;

  // Results still owed by the block, oldest first
  result_t            answers_due [$];

  int unsigned        miss_total;
  int unsigned        request_total;
  int unsigned        result_total;
  int unsigned        woken_total;
  int unsigned        full_total;

  function automatic void owe_answer(kind_e kind, logic [PortIdW-1:0] id, logic last);
    result_t r;
    r.kind = kind;
    r.id   = id;
    r.last = last;
    answers_due.push_back(r);
  endfunction

  // Insert: place before the first strictly later wake time, or refuse when full
  function automatic void apply_insert(logic [PortIdW-1:0] id, logic [WakeW-1:0] wake);
    int pos;
    int i;
    if (sleep_count >= QueueDepthDef) begin
      owe_answer(KIND_FULL, '0, 1'b1);
      return;
    end
    pos = sleep_count;
    for (i = 0; i < sleep_count; i++) begin
      if (sleep_wake[i] > wake) begin
        pos = i;
        break;
      end
    end
    for (i = sleep_count; i > pos; i--) begin
      sleep_wake[i] = sleep_wake[i-1];
      sleep_id[i]   = sleep_id[i-1];
    end
    sleep_wake[pos] = wake;
    sleep_id[pos]   = id & PortIdW'((1 << IdBitsDef) - 1);
    sleep_count++;
    owe_answer(KIND_ACCEPTED, '0, 1'b1);
  endfunction

  // Tick: advance the kernel tick, then wake every head entry that is now overdue
  function automatic void apply_tick(logic partial, logic [RelW-1:0] counter);
    logic [RelW-1:0] step;
    int popped;
    int i;
    step = reload_now;
    if (partial) begin
      step = reload_now - ((counter > reload_now) ? reload_now : counter);
    end
    kernel_now = kernel_now + WakeW'(step);
    popped = 0;
    while (popped < sleep_count && sleep_wake[popped] < kernel_now) popped++;
    if (popped == 0) begin
      owe_answer(KIND_NONE, '0, 1'b1);
      return;
    end
    for (i = 0; i < popped; i++) begin
      owe_answer(KIND_WOKEN, sleep_id[i], i == popped - 1);
    end
    for (i = popped; i < sleep_count; i++) begin
      sleep_wake[i-popped] = sleep_wake[i];
      sleep_id[i-popped]   = sleep_id[i];
    end
    sleep_count -= popped;
  endfunction

  // Watch both streams and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      kernel_now    = '0;
      sleep_count   = 0;
      reload_now    = '1;
      miss_total    = 0;
      request_total = 0;
      result_total  = 0;
      woken_total   = 0;
      full_total    = 0;
      answers_due.delete();
    end else begin
      // Register write; only index 0 exists
      if (psel && penable && pwrite && pready && paddr[ApbAddrW-1:2] == RegSelReload) begin
        reload_now = pwdata[RelW-1:0];
      end

      // Accepted request
      if (s_tvalid_i && s_tready_i) begin
        request_total++;
        if (s_tuser_i == ReqTick) begin
          apply_tick(s_tdata_i[InPartialLsb], s_tdata_i[InCounterLsb +: RelW]);
        end else begin
          apply_insert(s_tdata_i[InIdLsb +: PortIdW], s_tdata_i[InWakeLsb +: WakeW]);
        end
      end

      // Accepted result against the oldest owed one
      if (m_tvalid_i && m_tready_i) begin
        got.kind = kind_e'(m_tuser_i);
        got.id   = m_tdata_i;
        got.last = m_tlast_i;
        result_total++;
        if (got.kind == KIND_WOKEN) woken_total++;
        if (got.kind == KIND_FULL) full_total++;
        if (answers_due.size() == 0) begin
          miss_total++;
          if (miss_total <= ReportMax) begin
            $display("%0t checker: result kind=%0d id=%0d last=%0d with nothing owed",
                     $time, got.kind, got.id, got.last);
          end
        end else begin
          want = answers_due.pop_front();
          if (got.kind !== want.kind || got.id !== want.id || got.last !== want.last) begin
            miss_total++;
            if (miss_total <= ReportMax) begin
              $display("%0t checker: expected kind=%0d id=%0d last=%0d, got kind=%0d id=%0d last=%0d",
                       $time, want.kind, want.id, want.last, got.kind, got.id, got.last);
            end
          end
        end
      end
    end

    fail_count_o    <= miss_total;
    pending_o       <= answers_due.size();
    request_count_o <= request_total;
    result_count_o  <= result_total;
    woken_count_o   <= woken_total;
    full_count_o    <= full_total;
  end

endmodule

/* test/tb.sv */
// Testbench top for the sorted wakeup timer queue: stimulus, register writes and verdict.
module tb;
  import swtq_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseItems   = 80;
  localparam int unsigned BurstLen     = 18;

  localparam logic [ApbAddrW-1:0] ReloadAddr = {RegSelReload, 2'b00};
  localparam logic [ApbAddrW-1:0] SpareAddr  = {~RegSelReload, 2'b00};

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ApbAddrW-1:0] paddr           = '0;
  logic [ApbDataW-1:0] pwdata          = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // thread_id[7:0], wake_tick[71:8], partial_tick[72], counter_value[96:73]
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  // req_type[0]
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // woken_id[7:0]
  logic [PortIdW-1:0]  m_axis_tdata_o;
  // kind[1:0]
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned request_count;
  int unsigned result_count;
  int unsigned woken_count;
  int unsigned full_count;

  // Idle chances in percent, per cycle
  int unsigned send_idle_pct = 34;
  int unsigned take_idle_pct = 70;

  // Rough tracking of the kernel tick, used only to aim wake times
  logic [WakeW-1:0] tick_guess   = '0;
  logic [RelW-1:0]  reload_guess = '1;
  logic [WakeW-1:0] last_wake    = '0;

  int unsigned idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  sorted_wakeup_timer_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  swtq_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .s_tvalid_i      (s_axis_tvalid_i),
    .s_tready_i      (s_axis_tready_o),
    .s_tdata_i       (s_axis_tdata_i),
    .s_tuser_i       (s_axis_tuser_i),
    .m_tvalid_i      (m_axis_tvalid_o),
    .m_tready_i      (m_axis_tready_i),
    .m_tdata_i       (m_axis_tdata_o),
    .m_tuser_i       (m_axis_tuser_o),
    .m_tlast_i       (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .request_count_o (request_count),
    .result_count_o  (result_count),
    .woken_count_o   (woken_count),
    .full_count_o    (full_count)
  );

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= take_idle_pct);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles", IdleLimit);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request; valid stays high into the next request unless the sender idles
  task automatic send_request(logic req, logic [PortIdW-1:0] id, logic [WakeW-1:0] wake,
                              logic partial, logic [RelW-1:0] counter);
    logic [InDataW-1:0] word;
    word = '0;
    word[InIdLsb +: PortIdW]   = id;
    word[InWakeLsb +: WakeW]   = wake;
    word[InPartialLsb]         = partial;
    word[InCounterLsb +: RelW] = counter;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= req;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Insert; the tick fields carry noise
  task automatic insert_sleeper(logic [PortIdW-1:0] id, logic [WakeW-1:0] wake);
    send_request(ReqInsert, id, wake, 1'($urandom), RelW'($urandom));
  endtask

  // Tick; the insert fields carry noise
  task automatic timer_tick(logic partial, logic [RelW-1:0] counter);
    logic [RelW-1:0] step;
    step = reload_guess;
    if (partial) step = reload_guess - ((counter > reload_guess) ? reload_guess : counter);
    tick_guess = tick_guess + WakeW'(step);
    send_request(ReqTick, PortIdW'($urandom), {$urandom, $urandom}, partial, counter);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic reg_write(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr[ApbAddrW-1:2] == RegSelReload) reload_guess = value[RelW-1:0];
  endtask

  // Wait until every owed result has come, then let the block go quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly inserts aimed near the current tick, bursts that fill the queue, mixed ticks
  task automatic random_run(int unsigned count);
    int unsigned      burst_left;
    int unsigned      sel;
    int unsigned      off;
    logic [WakeW-1:0] wake;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0 && $urandom_range(24) == 0) burst_left = BurstLen;
      if (burst_left != 0 || $urandom_range(99) < 55) begin
        if (burst_left != 0) burst_left--;
        sel = $urandom_range(9);
        if (sel == 0) begin
          wake = last_wake;
        end else if (sel == 1) begin
          off  = $urandom_range(reload_guess);
          wake = (tick_guess > off) ? tick_guess - off : '0;
        end else begin
          wake = tick_guess + $urandom_range(3 * reload_guess);
        end
        insert_sleeper(PortIdW'($urandom), wake);
        last_wake = wake;
      end else begin
        sel = $urandom_range(3);
        if (sel == 0) timer_tick(1'b1, RelW'($urandom));
        else if (sel == 1) timer_tick(1'b1, RelW'($urandom_range(reload_guess)));
        else timer_tick(1'b0, RelW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme ids and wake times, equal wake times keep arrival order
    insert_sleeper(8'hFF, '1);
    insert_sleeper(8'h00, '0);
    insert_sleeper(8'd1, 64'd100);
    insert_sleeper(8'd2, 64'd100);
    insert_sleeper(8'd3, 64'd50);
    timer_tick(1'b1, '1);  // counter equal to reload: no advance, nothing due
    timer_tick(1'b1, '0);  // counter zero: full period, four wake up

    // Fill the queue, one insert too many is refused, one tick wakes all but the latest
    repeat (QueueDepthDef) begin
      insert_sleeper(PortIdW'($urandom), tick_guess + $urandom_range(reload_guess - 1));
    end
    timer_tick(1'b0, '0);
    settle();

    // Small reload: counter above reload is clamped; unmapped address is ignored
    reg_write(ReloadAddr, 32'd3);
    reg_write(SpareAddr, '1);
    timer_tick(1'b1, '1);
    timer_tick(1'b0, '0);
    settle();

    // Zero reload: ticks do not advance
    reg_write(ReloadAddr, '0);
    insert_sleeper(PortIdW'($urandom), tick_guess);
    timer_tick(1'b0, '0);
    settle();

    // Reload of one with junk in the upper write bits; sender light, receiver heavy
    reg_write(ReloadAddr, {8'hA5, 24'd1});
    random_run(PhaseItems);
    settle();

    // Full-range reload; sender heavy, receiver light
    send_idle_pct = 70;
    take_idle_pct = 34;
    reg_write(ReloadAddr, 32'h00FF_FFFF);
    random_run(PhaseItems);
    settle();

    // Random mid reload; no idling on either side
    send_idle_pct = 0;
    take_idle_pct = 0;
    reg_write(ReloadAddr, ApbDataW'($urandom_range(2, 5000)));
    random_run(PhaseItems);
    settle();

    $display("run covered %0d requests and %0d results, %0d wakeups, %0d refused inserts",
             request_count, result_count, woken_count, full_count);
    $display("reload 0, 1, 3, max and one random value under three idle patterns");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/swtq_pkg.sv
rtl/swtq_mem.sv
rtl/swtq_ctrl.sv
rtl/sorted_wakeup_timer_queue.sv
test/swtq_checker.sv
test/tb.sv
